>>> design/brp_pkg.sv
package brp_pkg;

  localparam int QueueDepth = 4;

  localparam int WordW    = 16;
  localparam int AddrW    = 32;
  localparam int BaseW    = 64;
  localparam int OffsetW  = 12;
  localparam int EntriesW = 31;
  localparam int CfgIdxW  = 2;

  localparam logic [3:0]       TypeNarrow = 4'h3;
  localparam logic [3:0]       TypeWide   = 4'hA;
  localparam logic [AddrW-1:0] HeaderSize = 32'd8;

  localparam logic [1:0] StPatch     = 2'd0;
  localparam logic [1:0] StEnd       = 2'd1;
  localparam logic [1:0] StMalformed = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgOldBase = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNewBase = 2'd1;

  typedef enum logic [2:0] {
    PH_PAGE_LO = 3'd0,
    PH_PAGE_HI = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_SIZE_HI = 3'd3,
    PH_ENTRY   = 3'd4,
    PH_STOP    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [AddrW-1:0]   page;
    logic [OffsetW-1:0] offset;
    logic               wide;
  } q_entry_t;

endpackage

>>> design/base_relocation_parser.sv
// Relocation directory parser: takes one 16-bit directory word per cycle
// while its queue is not full and emits a patch request for each type 3 or
// type 10 entry, a directory-end beat on a zero page address, or a malformed
// beat on a bad block size, then ignores words until reset. Each result is
// pushed into a queue of QUEUE_DEPTH entries, which sits between the word
// parser and the output register; dir words stall only while it is full.
module base_relocation_parser #(
  parameter int QUEUE_DEPTH = brp_pkg::QueueDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [brp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [brp_pkg::BaseW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [brp_pkg::WordW-1:0]     dir_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [brp_pkg::AddrW-1:0]     patch_offset,
  output logic                          patch_wide,
  output logic [brp_pkg::BaseW-1:0]     base_delta
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_not_empty;
  brp_pkg::q_entry_t q_wr_data;
  brp_pkg::q_entry_t q_rd_data;

  brp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dir_word (dir_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  brp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_rd_data)
  );

  brp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_not_empty  (q_not_empty),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .patch_offset (patch_offset),
    .patch_wide   (patch_wide),
    .base_delta   (base_delta)
  );

endmodule

>>> design/brp_front.sv
module brp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brp_pkg::WordW-1:0]       dir_word,
  input  logic                            q_full,
  output logic                            q_push,
  output brp_pkg::q_entry_t               q_data
);

  brp_pkg::phase_t phase;
  brp_pkg::phase_t phase_next;
  brp_pkg::phase_t phase_step;

  logic [brp_pkg::WordW-1:0]    low_half;
  logic [brp_pkg::AddrW-1:0]    page_addr;
  logic [brp_pkg::EntriesW-1:0] entries_left;

  logic                         accept;
  logic [brp_pkg::AddrW-1:0]    joined;
  logic                         malformed;
  logic [brp_pkg::AddrW-1:0]    size_body;
  logic [brp_pkg::EntriesW-1:0] size_entries;
  logic [brp_pkg::EntriesW-1:0] entries_dec;
  logic [3:0]                   entry_type;
  logic                         type_hit;

  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign joined       = {dir_word, low_half};
  assign malformed    = (joined < brp_pkg::HeaderSize) || joined[0];
  assign size_body    = joined - brp_pkg::HeaderSize;
  assign size_entries = size_body[brp_pkg::AddrW-1:1];
  assign entries_dec  = entries_left - brp_pkg::EntriesW'(1);
  assign entry_type   = dir_word[brp_pkg::WordW-1:brp_pkg::WordW-4];
  assign type_hit     = (entry_type == brp_pkg::TypeNarrow) ||
                        (entry_type == brp_pkg::TypeWide);

  // next state
  always_comb begin
    case (phase)
      brp_pkg::PH_PAGE_LO: phase_step = brp_pkg::PH_PAGE_HI;
      brp_pkg::PH_PAGE_HI: begin
        phase_step = (joined == '0) ? brp_pkg::PH_STOP : brp_pkg::PH_SIZE_LO;
      end
      brp_pkg::PH_SIZE_LO: phase_step = brp_pkg::PH_SIZE_HI;
      brp_pkg::PH_SIZE_HI: begin
        if (malformed) begin
          phase_step = brp_pkg::PH_STOP;
        end else if (size_entries == '0) begin
          phase_step = brp_pkg::PH_PAGE_LO;
        end else begin
          phase_step = brp_pkg::PH_ENTRY;
        end
      end
      brp_pkg::PH_ENTRY: begin
        phase_step = (entries_dec == '0) ? brp_pkg::PH_PAGE_LO : brp_pkg::PH_ENTRY;
      end
      default: phase_step = brp_pkg::PH_STOP;
    endcase
    phase_next = accept ? phase_step : phase;
  end

  // outputs
  always_comb begin
    q_push        = 1'b0;
    q_data.status = brp_pkg::StPatch;
    q_data.page   = page_addr;
    q_data.offset = dir_word[brp_pkg::OffsetW-1:0];
    q_data.wide   = (entry_type == brp_pkg::TypeWide);
    case (phase)
      brp_pkg::PH_PAGE_HI: begin
        q_push        = accept && (joined == '0);
        q_data.status = brp_pkg::StEnd;
      end
      brp_pkg::PH_SIZE_HI: begin
        q_push        = accept && malformed;
        q_data.status = brp_pkg::StMalformed;
      end
      brp_pkg::PH_ENTRY: begin
        q_push        = accept && type_hit;
        q_data.status = brp_pkg::StPatch;
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= brp_pkg::PH_PAGE_LO;
      low_half     <= '0;
      page_addr    <= '0;
      entries_left <= '0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        case (phase)
          brp_pkg::PH_PAGE_LO: low_half     <= dir_word;
          brp_pkg::PH_PAGE_HI: page_addr    <= joined;
          brp_pkg::PH_SIZE_LO: low_half     <= dir_word;
          brp_pkg::PH_SIZE_HI: entries_left <= size_entries;
          brp_pkg::PH_ENTRY:   entries_left <= entries_dec;
          default:             low_half     <= low_half;
        endcase
      end
    end
  end

endmodule

>>> design/brp_queue.sv
module brp_queue #(
  parameter int DEPTH = brp_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brp_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output brp_pkg::q_entry_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  brp_pkg::q_entry_t slots [DEPTH];

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> design/brp_back.sv
module brp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [brp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [brp_pkg::BaseW-1:0]     cfg_data,
  input  logic                          q_not_empty,
  input  brp_pkg::q_entry_t             q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [brp_pkg::AddrW-1:0]     patch_offset,
  output logic                          patch_wide,
  output logic [brp_pkg::BaseW-1:0]     base_delta
);

  logic [brp_pkg::BaseW-1:0] old_base;
  logic [brp_pkg::BaseW-1:0] new_base;
  logic                      is_patch;

  assign q_pop    = q_not_empty && (!out_valid || !out_stall);
  assign is_patch = (q_data.status == brp_pkg::StPatch);

  always_ff @(posedge clk) begin
    if (rst) begin
      old_base <= '0;
      new_base <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        brp_pkg::CfgOldBase: old_base <= cfg_data;
        brp_pkg::CfgNewBase: new_base <= cfg_data;
        default:             old_base <= old_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= q_pop || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status <= q_data.status;
      if (is_patch) begin
        patch_offset <= q_data.page + brp_pkg::AddrW'(q_data.offset);
        patch_wide   <= q_data.wide;
        base_delta   <= new_base - old_base;
      end else begin
        patch_offset <= '0;
        patch_wide   <= 1'b0;
        base_delta   <= '0;
      end
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 400000;
  localparam int DirRows = 25;
  localparam int PhaseWords = 200;
  localparam int HoldCycles = 80;
  localparam int SettleCycles = 8;
  localparam int MaxReports = 30;
  localparam logic [brp_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam logic [brp_pkg::BaseW-1:0] AllOnes = '1;

  typedef struct packed {
    logic [1:0]                status;
    logic [brp_pkg::AddrW-1:0] offset;
    logic                      wide;
    logic [brp_pkg::BaseW-1:0] delta;
  } reloc_beat_t;

  typedef struct packed {
    logic [brp_pkg::WordW-1:0] word;
    logic                      typed;
    logic                      hit;
    reloc_beat_t               beat;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [brp_pkg::CfgIdxW-1:0] cfg_index;
  logic [brp_pkg::BaseW-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [brp_pkg::WordW-1:0] dir_word;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic [brp_pkg::AddrW-1:0] patch_offset;
  logic patch_wide;
  logic [brp_pkg::BaseW-1:0] base_delta;

  // directory parser state as seen from outside
  brp_pkg::phase_t dir_phase;
  logic [brp_pkg::WordW-1:0] half_word;
  logic [brp_pkg::AddrW-1:0] cur_page;
  logic [brp_pkg::EntriesW-1:0] entries_left;
  logic [brp_pkg::BaseW-1:0] old_base;
  logic [brp_pkg::BaseW-1:0] new_base;

  reloc_beat_t pending_beats[$];
  int errors = 0;
  int words_sent = 0;
  int beats_seen = 0;
  int blocks_sent = 0;
  int cycle_count = 0;
  bit calm = 0;
  bit hold_req = 0;

  base_relocation_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .dir_word     (dir_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .patch_offset (patch_offset),
    .patch_wide   (patch_wide),
    .base_delta   (base_delta)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL base_relocation_parser");
    $finish;
  end

  function automatic bit parse_dir_word(input logic [brp_pkg::WordW-1:0] w,
                                        output reloc_beat_t r);
    logic [brp_pkg::AddrW-1:0] size;
    logic [brp_pkg::AddrW-1:0] span;
    bit hit;
    hit = 0;
    r = '0;
    case (dir_phase)
      brp_pkg::PH_PAGE_LO: begin
        half_word = w;
        dir_phase = brp_pkg::PH_PAGE_HI;
      end
      brp_pkg::PH_PAGE_HI: begin
        cur_page = {w, half_word};
        if (cur_page == '0) begin
          dir_phase = brp_pkg::PH_STOP;
          r.status = brp_pkg::StEnd;
          hit = 1;
        end else begin
          dir_phase = brp_pkg::PH_SIZE_LO;
        end
      end
      brp_pkg::PH_SIZE_LO: begin
        half_word = w;
        dir_phase = brp_pkg::PH_SIZE_HI;
      end
      brp_pkg::PH_SIZE_HI: begin
        size = {w, half_word};
        if (size < brp_pkg::HeaderSize || size[0]) begin
          dir_phase = brp_pkg::PH_STOP;
          r.status = brp_pkg::StMalformed;
          hit = 1;
        end else begin
          span = (size - brp_pkg::HeaderSize) >> 1;
          entries_left = span[brp_pkg::EntriesW-1:0];
          dir_phase = (entries_left == '0) ? brp_pkg::PH_PAGE_LO : brp_pkg::PH_ENTRY;
        end
      end
      brp_pkg::PH_ENTRY: begin
        entries_left = entries_left - brp_pkg::EntriesW'(1);
        if (entries_left == '0) dir_phase = brp_pkg::PH_PAGE_LO;
        if (w[15:12] == brp_pkg::TypeNarrow || w[15:12] == brp_pkg::TypeWide) begin
          hit = 1;
          r.status = brp_pkg::StPatch;
          r.offset = cur_page + {{(brp_pkg::AddrW-brp_pkg::OffsetW){1'b0}},
                                 w[brp_pkg::OffsetW-1:0]};
          r.wide = (w[15:12] == brp_pkg::TypeWide);
          r.delta = new_base - old_base;
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic dir_row_t plain(input logic [brp_pkg::WordW-1:0] w);
    dir_row_t r;
    r = '0;
    r.word = w;
    return r;
  endfunction

  // patch beat with reset bases, so the delta is zero
  function automatic dir_row_t known(input logic [brp_pkg::WordW-1:0] w,
                                     input logic [brp_pkg::AddrW-1:0] off,
                                     input logic wide);
    dir_row_t r;
    r = '0;
    r.word = w;
    r.typed = 1;
    r.hit = 1;
    r.beat.status = brp_pkg::StPatch;
    r.beat.offset = off;
    r.beat.wide = wide;
    return r;
  endfunction

  function automatic int idle_draw();
    if (calm) return 0;
    return $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 16));
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= MaxReports)
      $display("mismatch %s at beat %0d: expected %h, got %h", what, beats_seen, want, got);
  endtask

  task automatic check_beat();
    reloc_beat_t want;
    beats_seen++;
    if (pending_beats.size() == 0) begin
      report("unexpected beat, status", '0, 64'(status));
      return;
    end
    want = pending_beats.pop_front();
    if (status !== want.status) report("status", 64'(want.status), 64'(status));
    if (patch_offset !== want.offset)
      report("patch_offset", 64'(want.offset), 64'(patch_offset));
    if (patch_wide !== want.wide) report("patch_wide", 64'(want.wide), 64'(patch_wide));
    if (base_delta !== want.delta) report("base_delta", want.delta, base_delta);
  endtask

  task automatic send_word(input dir_row_t row);
    int gap;
    bit hit;
    reloc_beat_t got;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_word <= row.word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit = parse_dir_word(row.word, got);
    if (row.typed) begin
      hit = row.hit;
      got = row.beat;
    end
    if (hit) pending_beats.push_back(got);
    words_sent++;
  endtask

  task automatic send_block(input int n, input bit dense);
    logic [brp_pkg::AddrW-1:0] page;
    logic [brp_pkg::AddrW-1:0] size;
    logic [brp_pkg::WordW-1:0] w;
    int k;
    page = $urandom;
    if (page == '0) page = 32'h1;
    size = brp_pkg::HeaderSize + 32'(2 * n);
    send_word(plain(page[15:0]));
    send_word(plain(page[31:16]));
    send_word(plain(size[15:0]));
    send_word(plain(size[31:16]));
    repeat (n) begin
      w = 16'($urandom);
      k = dense ? $urandom_range(0, 6) : $urandom_range(0, 9);
      if (k < 4) w[15:12] = brp_pkg::TypeNarrow;
      else if (k < 7) w[15:12] = brp_pkg::TypeWide;
      send_word(plain(w));
    end
    blocks_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_bases(input logic [brp_pkg::BaseW-1:0] old_v,
                           input logic [brp_pkg::BaseW-1:0] new_v);
    cfg_write_en <= 1'b1;
    cfg_index <= brp_pkg::CfgOldBase;
    cfg_data <= old_v;
    @(posedge clk);
    cfg_index <= brp_pkg::CfgNewBase;
    cfg_data <= new_v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    old_base = old_v;
    new_base = new_v;
  endtask

  // receiver: per-beat stall draw, long hold on request
  initial begin
    int stall_left;
    bit took;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      if (took) check_beat();
      if (hold_req) begin
        hold_req = 0;
        stall_left = HoldCycles;
      end else if (took) begin
        stall_left = idle_draw();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin
    dir_row_t dir_table [DirRows];
    logic [brp_pkg::BaseW-1:0] base_a;
    logic [brp_pkg::AddrW-1:0] page;
    logic [brp_pkg::AddrW-1:0] size;
    int start;
    int kind;
    int n;
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index <= brp_pkg::CfgOldBase;
    cfg_data <= '0;
    in_valid <= 1'b0;
    dir_word <= '0;
    dir_phase = brp_pkg::PH_PAGE_LO;
    half_word = '0;
    cur_page = '0;
    entries_left = '0;
    old_base = '0;
    new_base = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unused register index, must leave both bases alone
    cfg_write_en <= 1'b1;
    cfg_index <= CfgSpare;
    cfg_data <= AllOnes;
    @(posedge clk);
    cfg_write_en <= 1'b0;

    dir_table = '{
      plain(16'h0000), plain(16'h0001), plain(16'h000C), plain(16'h0000),
      known(16'h3FFF, 32'h0001_0FFF, 1'b0),
      known(16'hA000, 32'h0001_0000, 1'b1),
      plain(16'hFFFF), plain(16'hFFFF), plain(16'h000A), plain(16'h0000),
      known(16'h3FFF, 32'h0000_0FFE, 1'b0),
      plain(16'hF000), plain(16'hFFFF), plain(16'h0014), plain(16'h0000),
      plain(16'h0FFF),
      known(16'h3001, 32'hFFFF_F001, 1'b0),
      known(16'hAFFF, 32'hFFFF_FFFF, 1'b1),
      plain(16'hFFFF), plain(16'hB123), plain(16'h2ABC),
      plain(16'h1234), plain(16'h8765), plain(16'h0008), plain(16'h0000)
    };
    foreach (dir_table[i]) send_word(dir_table[i]);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_bases('0, AllOnes);
        1: set_bases(AllOnes, '0);
        2: begin
          base_a = {$urandom, $urandom};
          set_bases(base_a, base_a);
        end
        default: set_bases({$urandom, $urandom}, {$urandom, $urandom});
      endcase
      start = words_sent;
      if (ph == 2) begin
        // back up the result queue until the input stalls
        hold_req = 1;
        calm = 1;
        send_block(30, 1);
      end
      calm = (ph == 4);
      while (words_sent - start < PhaseWords) begin
        if (ph != 4) calm = ($urandom_range(0, 7) == 0);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
        send_block(n, 0);
      end
      calm = 0;
      drain();
    end

    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      send_word(plain(16'h0000));
      send_word(plain(16'h0000));
    end else begin
      page = $urandom;
      if (page == '0) page = 32'h1;
      size = (kind == 1) ? ($urandom | 32'h1) : 32'($urandom_range(0, 7));
      send_word(plain(page[15:0]));
      send_word(plain(page[31:16]));
      send_word(plain(size[15:0]));
      send_word(plain(size[31:16]));
    end
    // parser is stopped, these must produce nothing
    repeat (4) send_word(plain(16'($urandom)));
    drain();

    $display("run covered %0d directory words, %0d random blocks, %0d result beats in %0d cycles",
             words_sent, blocks_sent, beats_seen, cycle_count);
    $display("directory closed by %s", (kind == 0) ? "a zero page address" : "a bad block size");
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("PASS base_relocation_parser");
    end else begin
      $display("FAIL base_relocation_parser");
    end
    $finish;
  end

endmodule
